// File: src/ebam_pkg.sv
// ----------------------------------------------------------------------------
// ebam_pkg
// Shared widths, event kinds, action codes and register indexes of the
// encoder button action mapper.
// ----------------------------------------------------------------------------
package ebam_pkg;

    // field widths
    localparam int KIND_W  = 2;
    localparam int DELTA_W = 16;
    localparam int TIME_W  = 32;
    localparam int ACT_W   = 3;
    localparam int STEP_W  = 8;
    localparam int MSEC_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [MSEC_W-1:0] t_msec;
    typedef logic [TIME_W-1:0] t_time;

    // event kinds
    localparam t_kind KIND_ROTATE = 2'd0;
    localparam t_kind KIND_BUTTON = 2'd1;
    localparam t_kind KIND_POLL   = 2'd2;

    // action codes
    localparam t_action ACT_NONE   = 3'd0;
    localparam t_action ACT_NEXT   = 3'd1;
    localparam t_action ACT_PREV   = 3'd2;
    localparam t_action ACT_INC    = 3'd3;
    localparam t_action ACT_DEC    = 3'd4;
    localparam t_action ACT_ENTER  = 3'd5;
    localparam t_action ACT_CANCEL = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EDIT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP   = 3'd4;

    // register reset values
    localparam t_msec RST_LONG_PRESS  = 16'd1000;
    localparam t_msec RST_ACCEL_START = 16'd1500;
    localparam t_step RST_NORMAL_STEP = 8'd1;
    localparam t_step RST_FAST_STEP   = 8'd5;

endpackage

// File: src/ebam_evt_if.sv
// ----------------------------------------------------------------------------
// ebam_evt_if
// Event channel: kind, rotation delta, button level and timestamp.
// ----------------------------------------------------------------------------
interface ebam_evt_if;
    logic                                valid;
    logic                                ready;
    logic [ebam_pkg::KIND_W-1:0]         kind;
    logic signed [ebam_pkg::DELTA_W-1:0] rotate_delta;
    logic                                button_down;
    logic [ebam_pkg::TIME_W-1:0]         time_ms;

    modport source (output valid, kind, rotate_delta, button_down, time_ms, input ready);
    modport sink   (input valid, kind, rotate_delta, button_down, time_ms, output ready);
endinterface

// File: src/ebam_act_if.sv
// ----------------------------------------------------------------------------
// ebam_act_if
// Action channel: user-interface action and current step size.
// ----------------------------------------------------------------------------
interface ebam_act_if;
    logic                         valid;
    logic                         ready;
    logic [ebam_pkg::ACT_W-1:0]   action;
    logic [ebam_pkg::STEP_W-1:0]  step_size;

    modport source (output valid, action, step_size, input ready);
    modport sink   (input valid, action, step_size, output ready);
endinterface

// File: src/encoder_button_action_mapper.sv
// ----------------------------------------------------------------------------
// encoder_button_action_mapper
// Maps rotary encoder, button level and poll events to UI actions with
// long-press cancel, queued enter and step-size acceleration.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one event per word (rotation, button level or poll tick).
//   o_act returns exactly one word per event: the action and the step size
//   in effect after that event.
//   An event is captured in an input register, evaluated against the button
//   state once the output register is free, and written to the output register,
//   which holds the result until the receiver takes it. Throughput is one
//   event per cycle while the receiver does not stall; the single evaluation
//   step (one 32-bit held-time subtract and two 32-bit compares against the
//   zero-extended 16-bit thresholds) is combinational.
//   When the receiver stalls, the output register holds its word and the
//   input register can still take one more event before i_evt.ready drops.
//   Reset empties both registers, clears the button state and loads the
//   register defaults (edit off, 1000 ms long press, 1500 ms accel, steps
//   1 and 5).
//   Configuration writes through i_cfg_we / i_cfg_idx / i_cfg_data are to be
//   made by the user while no event is in flight; the block does not enforce
//   it. Timing and step writes reload the current step from the normal step size.
// ----------------------------------------------------------------------------
module encoder_button_action_mapper (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ebam_evt_if.sink                          i_evt,
    ebam_act_if.source                        o_act,
    input  logic                              i_cfg_we,
    input  logic [ebam_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ebam_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ebam_pkg::*;

    // configuration registers
    logic  r_edit_mode;
    t_msec r_long_press;
    t_msec r_accel_start;
    t_step r_normal_step;
    t_step r_fast_step;

    // button state
    logic  r_btn_down;
    t_time r_press_start;
    logic  r_long_done;
    logic  r_enter_pend;
    t_step r_cur_step;
    logic  n_btn_down;
    t_time n_press_start;
    logic  n_long_done;
    logic  n_enter_pend;
    t_step n_cur_step;

    // input register
    logic                r_in_valid;
    t_kind               r_kind;
    logic [DELTA_W-1:0]  r_delta;
    logic                r_button;
    t_time               r_time;

    // output register
    logic    r_out_valid;
    t_action r_action;
    t_step   r_step;
    t_action n_action;

    logic          out_free;
    logic          proc;
    logic [TIME_W:0] held_diff;
    t_time         held;
    logic          held_long;
    logic          held_accel;

    // pipeline flow control
    assign out_free    = !r_out_valid || o_act.ready;
    assign proc        = r_in_valid && out_free;
    assign i_evt.ready = !r_in_valid || out_free;

    assign o_act.valid     = r_out_valid;
    assign o_act.action    = r_action;
    assign o_act.step_size = r_step;

    // held time since press, floored at zero
    assign held_diff  = {1'b0, r_time} - {1'b0, r_press_start};
    assign held       = held_diff[TIME_W] ? '0 : held_diff[TIME_W-1:0];
    assign held_long  = held >= {{(TIME_W-MSEC_W){1'b0}}, r_long_press};
    assign held_accel = held >= {{(TIME_W-MSEC_W){1'b0}}, r_accel_start};

    // event evaluation
    always_comb begin
        n_btn_down    = r_btn_down;
        n_press_start = r_press_start;
        n_long_done   = r_long_done;
        n_enter_pend  = r_enter_pend;
        n_cur_step    = r_cur_step;
        n_action      = ACT_NONE;
        case (r_kind)
            KIND_ROTATE: begin
                if (r_delta == '0) begin
                    n_action = ACT_NONE;
                end else if (r_delta[DELTA_W-1]) begin
                    n_action = r_edit_mode ? ACT_DEC : ACT_PREV;
                end else begin
                    n_action = r_edit_mode ? ACT_INC : ACT_NEXT;
                end
            end
            KIND_BUTTON: begin
                if (r_button != r_btn_down) begin
                    n_btn_down  = r_button;
                    n_long_done = 1'b0;
                    n_cur_step  = r_normal_step;
                    if (r_button) begin
                        n_press_start = r_time;
                    end else begin
                        n_press_start = '0;
                        if (!r_long_done && !held_long) begin
                            n_enter_pend = 1'b1;
                        end
                    end
                end
            end
            KIND_POLL: begin
                if (r_enter_pend) begin
                    n_enter_pend = 1'b0;
                    n_action     = ACT_ENTER;
                end else if (r_btn_down) begin
                    n_cur_step = held_accel ? r_fast_step : r_normal_step;
                    if (!r_long_done && held_long) begin
                        n_long_done = 1'b1;
                        n_action    = ACT_CANCEL;
                    end
                end
            end
            default: begin
                n_action = ACT_NONE;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
        if (i_evt.valid && i_evt.ready) begin
            r_kind   <= i_evt.kind;
            r_delta  <= i_evt.rotate_delta;
            r_button <= i_evt.button_down;
            r_time   <= i_evt.time_ms;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (proc) begin
            r_action <= n_action;
            r_step   <= n_cur_step;
        end
    end

    // button state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edit_mode   <= 1'b0;
            r_long_press  <= RST_LONG_PRESS;
            r_accel_start <= RST_ACCEL_START;
            r_normal_step <= RST_NORMAL_STEP;
            r_fast_step   <= RST_FAST_STEP;
            r_btn_down    <= 1'b0;
            r_press_start <= '0;
            r_long_done   <= 1'b0;
            r_enter_pend  <= 1'b0;
            r_cur_step    <= RST_NORMAL_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EDIT_MODE: begin
                    r_edit_mode <= i_cfg_data[0];
                end
                CFG_LONG_PRESS: begin
                    r_long_press <= i_cfg_data;
                    r_cur_step   <= r_normal_step;
                end
                CFG_ACCEL_START: begin
                    r_accel_start <= i_cfg_data;
                    r_cur_step    <= r_normal_step;
                end
                CFG_NORMAL_STEP: begin
                    r_normal_step <= i_cfg_data[STEP_W-1:0];
                    r_cur_step    <= i_cfg_data[STEP_W-1:0];
                end
                CFG_FAST_STEP: begin
                    r_fast_step <= i_cfg_data[STEP_W-1:0];
                    r_cur_step  <= r_normal_step;
                end
                default: begin
                    r_edit_mode <= r_edit_mode;
                end
            endcase
        end else if (proc) begin
            r_btn_down    <= n_btn_down;
            r_press_start <= n_press_start;
            r_long_done   <= n_long_done;
            r_enter_pend  <= n_enter_pend;
            r_cur_step    <= n_cur_step;
        end
    end

`ifndef SYNTH
    // long press can only be flagged while the button is held
    a_long_needs_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_done |-> r_btn_down)
        else $error("long press flag set with button released");

    // a released button leaves no press start time
    a_start_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_btn_down |-> (r_press_start == '0))
        else $error("press start not cleared on release");

    // a cancel marks the long press done
    a_cancel_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && !i_cfg_we && n_action == ACT_CANCEL) |=> r_long_done)
        else $error("cancel issued without marking long press");

    // a poll consumes a pending enter
    a_enter_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && !i_cfg_we && r_kind == KIND_POLL && r_enter_pend) |=> !r_enter_pend)
        else $error("pending enter not cleared by poll");
`endif

endmodule

// File: bench/encoder_button_action_mapper_tb.sv
// ----------------------------------------------------------------------------
// encoder_button_action_mapper_tb
// Self-checking bench for the encoder button action mapper. A table of
// directed events covers the delta extremes, ignored button levels, the
// unused kind, queued enter, one-shot cancel, acceleration and timestamps
// that fall before the press. After that, random gestures run under several
// register settings and idle/stall mixes. Every result word is checked
// against a fixed row value or an in-bench model of the button state machine.
// ----------------------------------------------------------------------------
module encoder_button_action_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ebam_pkg::*;

    localparam int    DIR_ROWS        = 25;
    localparam int    PHASES          = 8;
    localparam int    ITEMS_PER_PHASE = 65;
    localparam int    SETTLE_CYCLES   = 4;
    localparam int    HOLD_CYCLES     = 60;
    localparam int    WATCHDOG_LIMIT  = 1000;
    localparam t_kind KIND_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        t_kind              kind;
        logic [DELTA_W-1:0] delta;
        logic               down;
        t_time              stamp;
    } evt_word_t;

    typedef struct packed {
        t_action action;
        t_step   step;
    } act_word_t;

    typedef struct packed {
        evt_word_t w;
        logic      typed;
        act_word_t fixed;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ebam_evt_if evt ();
    ebam_act_if act ();

    encoder_button_action_mapper DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt),
        .o_act      (act),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // mapper registers and button state as the bench sees them
    logic  m_edit;
    t_msec m_long_press;
    t_msec m_accel_start;
    t_step m_normal_step;
    t_step m_fast_step;
    logic  m_btn_down;
    t_time m_press_start;
    logic  m_long_done;
    logic  m_enter_pending;
    t_step m_cur_step;

    act_word_t pending_actions [$];
    t_time     clock_ms;
    int        sent_count  = 0;
    int        send_pct    = 0;
    int        recv_pct    = 0;
    int        hold_reqs   = 0;
    int        fail_cnt    = 0;
    int        idle_cycles = 0;
    int        n_results   = 0;
    int        n_enter     = 0;
    int        n_cancel    = 0;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic evt_word_t evt_word(input t_kind k, input logic [DELTA_W-1:0] d,
                                           input logic b, input t_time t);
        return '{k, d, b, t};
    endfunction

    function automatic dir_row_t dir_row(input evt_word_t w, input logic typed,
                                         input t_action a, input t_step s);
        return '{w, typed, '{a, s}};
    endfunction

    // next action and step size for one event, advancing the button state
    function automatic void map_event(input evt_word_t w, output t_action a, output t_step s);
        t_time held;
        held = (w.stamp >= m_press_start) ? w.stamp - m_press_start : '0;
        a = ACT_NONE;
        case (w.kind)
            KIND_ROTATE: begin
                if (w.delta != '0) begin
                    if (w.delta[DELTA_W-1]) a = m_edit ? ACT_DEC : ACT_PREV;
                    else a = m_edit ? ACT_INC : ACT_NEXT;
                end
            end
            KIND_BUTTON: begin
                // same level again is ignored
                if (w.down != m_btn_down) begin
                    m_btn_down = w.down;
                    if (w.down) begin
                        m_press_start = w.stamp;
                    end else begin
                        if (!m_long_done && held < t_time'(m_long_press)) m_enter_pending = 1'b1;
                        m_press_start = '0;
                    end
                    m_long_done = 1'b0;
                    m_cur_step  = m_normal_step;
                end
            end
            KIND_POLL: begin
                if (m_enter_pending) begin
                    m_enter_pending = 1'b0;
                    a = ACT_ENTER;
                end else if (m_btn_down) begin
                    m_cur_step = (held >= t_time'(m_accel_start)) ? m_fast_step : m_normal_step;
                    if (!m_long_done && held >= t_time'(m_long_press)) begin
                        m_long_done = 1'b1;
                        a = ACT_CANCEL;
                    end
                end
            end
            default: ;
        endcase
        s = m_cur_step;
    endfunction

    // offer one event word, then record what it should return
    task automatic send_event(input evt_word_t w, input logic typed = 1'b0,
                              input act_word_t fixed = '0);
        t_action a;
        t_step   s;
        act_word_t want;
        while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
            evt.valid <= 1'b0;
            @(posedge i_clk);
        end
        evt.valid        <= 1'b1;
        evt.kind         <= w.kind;
        evt.rotate_delta <= w.delta;
        evt.button_down  <= w.down;
        evt.time_ms      <= w.stamp;
        @(posedge i_clk);
        while (!evt.ready) @(posedge i_clk);
        map_event(w, a, s);
        if (typed) want = fixed;
        else want = '{a, s};
        pending_actions.push_back(want);
        sent_count++;
    endtask

    // stop offering and wait until every result word is back
    task automatic drain_pipeline;
        evt.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_EDIT_MODE:   m_edit        = data[0];
            CFG_LONG_PRESS:  m_long_press  = data;
            CFG_ACCEL_START: m_accel_start = data;
            CFG_NORMAL_STEP: m_normal_step = data[STEP_W-1:0];
            CFG_FAST_STEP:   m_fast_step   = data[STEP_W-1:0];
            default: ;
        endcase
        // timing and step writes reload the current step
        if (idx != CFG_EDIT_MODE && idx <= CFG_FAST_STEP) m_cur_step = m_normal_step;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_registers(input logic [CFG_DATA_W-1:0] edit, input logic [CFG_DATA_W-1:0] lp,
                                 input logic [CFG_DATA_W-1:0] accel,
                                 input logic [CFG_DATA_W-1:0] norm,
                                 input logic [CFG_DATA_W-1:0] fast);
        drain_pipeline;
        write_reg(CFG_EDIT_MODE, edit);
        write_reg(CFG_LONG_PRESS, lp);
        write_reg(CFG_ACCEL_START, accel);
        write_reg(CFG_NORMAL_STEP, norm);
        write_reg(CFG_FAST_STEP, fast);
    endtask

    // mostly press/poll/release gestures with random timing, some noise words
    task automatic run_random(input int n);
        int                 stop_at;
        int                 span;
        int                 polls;
        t_time              press_at;
        logic [DELTA_W-1:0] spin;
        stop_at = sent_count + n;
        while (sent_count < stop_at) begin
            span = ((m_long_press > m_accel_start) ? int'(m_long_press) : int'(m_accel_start)) + 2;
            spin = DELTA_W'($urandom);
            if ($urandom_range(0, 5) == 0) spin = '0;
            // occasional jump anywhere, so timestamps wrap now and then
            if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
            case ($urandom_range(0, 9))
                0: send_event(evt_word(t_kind'($urandom_range(0, 3)), spin, 1'($urandom),
                                       ($urandom_range(0, 1) == 1) ? $urandom : clock_ms));
                1, 2: send_event(evt_word(KIND_ROTATE, spin, 1'b0, clock_ms));
                default: begin
                    clock_ms += $urandom_range(0, span);
                    press_at = clock_ms;
                    send_event(evt_word(KIND_BUTTON, spin, 1'b1, clock_ms));
                    polls = $urandom_range(0, 5);
                    repeat (polls) begin
                        clock_ms += $urandom_range(0, span / 2);
                        case ($urandom_range(0, 7))
                            0: send_event(evt_word(KIND_POLL, spin, 1'b0,
                                                   press_at - $urandom_range(1, 500)));
                            1: send_event(evt_word(KIND_ROTATE, spin, 1'b1, clock_ms));
                            default: send_event(evt_word(KIND_POLL, spin, 1'b0, clock_ms));
                        endcase
                    end
                    clock_ms += $urandom_range(0, span / 2);
                    send_event(evt_word(KIND_BUTTON, spin, 1'b0, clock_ms));
                    send_event(evt_word(KIND_POLL, spin, 1'b0, clock_ms));
                end
            endcase
        end
    endtask

    // result side: random stalls plus a long hold-off on request
    initial begin : result_sink
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        act.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
                act.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                act.ready <= 1'b0;
            end else begin
                act.ready <= ($urandom_range(0, 99) >= recv_pct);
            end
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        act_word_t want;
        if (i_rst_n && act.valid && act.ready) begin
            if (pending_actions.size() == 0) begin
                $error("unexpected word: action %0d step_size %0d", act.action, act.step_size);
                fail_cnt++;
            end else begin
                want = pending_actions.pop_front();
                if (act.action !== want.action) begin
                    $error("action: expected %0d, actual %0d", want.action, act.action);
                    fail_cnt++;
                end
                if (act.step_size !== want.step) begin
                    $error("step_size: expected %0d, actual %0d", want.step, act.step_size);
                    fail_cnt++;
                end
                n_results++;
                if (want.action == ACT_ENTER) n_enter++;
                if (want.action == ACT_CANCEL) n_cancel++;
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (evt.valid && evt.ready) || (act.valid && act.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t rows [DIR_ROWS];
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        evt.valid        = 1'b0;
        evt.kind         = KIND_ROTATE;
        evt.rotate_delta = '0;
        evt.button_down  = 1'b0;
        evt.time_ms      = '0;
        clock_ms         = '0;

        // state after reset
        m_edit          = 1'b0;
        m_long_press    = RST_LONG_PRESS;
        m_accel_start   = RST_ACCEL_START;
        m_normal_step   = RST_NORMAL_STEP;
        m_fast_step     = RST_FAST_STEP;
        m_btn_down      = 1'b0;
        m_press_start   = '0;
        m_long_done     = 1'b0;
        m_enter_pending = 1'b0;
        m_cur_step      = RST_NORMAL_STEP;

        // delta extremes, zero delta, idle poll, repeated level, unused kind
        rows[0]  = dir_row(evt_word(KIND_ROTATE, 16'h0001, 1'b0, 32'd0), 1'b1,
                           ACT_NEXT, RST_NORMAL_STEP);
        rows[1]  = dir_row(evt_word(KIND_ROTATE, 16'h7FFF, 1'b0, 32'd0), 1'b1,
                           ACT_NEXT, RST_NORMAL_STEP);
        rows[2]  = dir_row(evt_word(KIND_ROTATE, 16'h8000, 1'b1, 32'hFFFF_FFFF), 1'b1,
                           ACT_PREV, RST_NORMAL_STEP);
        rows[3]  = dir_row(evt_word(KIND_ROTATE, 16'hFFFF, 1'b0, 32'd0), 1'b0, ACT_NONE, '0);
        rows[4]  = dir_row(evt_word(KIND_ROTATE, 16'h0000, 1'b0, 32'd0), 1'b1,
                           ACT_NONE, RST_NORMAL_STEP);
        rows[5]  = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd0), 1'b1,
                           ACT_NONE, RST_NORMAL_STEP);
        rows[6]  = dir_row(evt_word(KIND_BUTTON, 16'h0000, 1'b0, 32'd5), 1'b1,
                           ACT_NONE, RST_NORMAL_STEP);
        rows[7]  = dir_row(evt_word(KIND_UNUSED, 16'h7FFF, 1'b1, 32'hFFFF_FFFF), 1'b1,
                           ACT_NONE, RST_NORMAL_STEP);
        // short press gives enter on the next poll
        rows[8]  = dir_row(evt_word(KIND_BUTTON, 16'h0000, 1'b1, 32'd100), 1'b0, ACT_NONE, '0);
        rows[9]  = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd600), 1'b0, ACT_NONE, '0);
        rows[10] = dir_row(evt_word(KIND_BUTTON, 16'h0000, 1'b0, 32'd700), 1'b0, ACT_NONE, '0);
        rows[11] = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd800), 1'b1,
                           ACT_ENTER, RST_NORMAL_STEP);
        rows[12] = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd900), 1'b0, ACT_NONE, '0);
        // long press: cancel once, then fast step, no enter on release
        rows[13] = dir_row(evt_word(KIND_BUTTON, 16'h0000, 1'b1, 32'd1000), 1'b0, ACT_NONE, '0);
        rows[14] = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd2000), 1'b0, ACT_NONE, '0);
        rows[15] = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd2500), 1'b0, ACT_NONE, '0);
        rows[16] = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd3000), 1'b0, ACT_NONE, '0);
        rows[17] = dir_row(evt_word(KIND_ROTATE, 16'h0003, 1'b0, 32'd3000), 1'b0, ACT_NONE, '0);
        rows[18] = dir_row(evt_word(KIND_BUTTON, 16'h0000, 1'b0, 32'd3100), 1'b0, ACT_NONE, '0);
        rows[19] = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd3200), 1'b0, ACT_NONE, '0);
        // timestamps wrapping below the press start count as zero held time
        rows[20] = dir_row(evt_word(KIND_BUTTON, 16'h0000, 1'b1, 32'hFFFF_FF00), 1'b0,
                           ACT_NONE, '0);
        rows[21] = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'h0000_0010), 1'b0, ACT_NONE, '0);
        rows[22] = dir_row(evt_word(KIND_BUTTON, 16'h0000, 1'b1, 32'd0), 1'b0, ACT_NONE, '0);
        rows[23] = dir_row(evt_word(KIND_BUTTON, 16'h0000, 1'b0, 32'h0000_0020), 1'b0,
                           ACT_NONE, '0);
        rows[24] = dir_row(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'hFFFF_FFFF), 1'b0, ACT_NONE, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) send_event(rows[i].w, rows[i].typed, rows[i].fixed);

        // zero thresholds, wide data masked to register width
        drain_pipeline;
        write_reg(CFG_LONG_PRESS, 16'h0000);
        write_reg(CFG_ACCEL_START, 16'h0000);
        write_reg(CFG_NORMAL_STEP, 16'h5A3C);
        write_reg(CFG_FAST_STEP, 16'hA5C3);
        send_event(evt_word(KIND_BUTTON, 16'h0000, 1'b1, 32'd50));
        send_event(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd50));
        // edit mode and a write past the register list leave the step alone
        drain_pipeline;
        write_reg(CFG_EDIT_MODE, 16'h0001);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        send_event(evt_word(KIND_ROTATE, 16'h0005, 1'b0, 32'd55));
        send_event(evt_word(KIND_ROTATE, 16'hFFFB, 1'b0, 32'd55));
        send_event(evt_word(KIND_BUTTON, 16'h0000, 1'b0, 32'd60));
        send_event(evt_word(KIND_POLL, 16'h0000, 1'b0, 32'd60));
        send_event(evt_word(KIND_ROTATE, 16'h0001, 1'b0, 32'd60));

        // random gestures under several settings and idle/stall mixes
        for (int ph = 0; ph < PHASES; ph++) begin
            send_pct = (ph % 4 == 1) ? 52 : (ph % 4 == 3) ? 33 : 0;
            recv_pct <= (ph % 4 == 2) ? 52 : (ph % 4 == 3) ? 33 : 0;
            case (ph)
                0: set_registers(16'd0, 16'd1000, 16'd1500, 16'd1, 16'd5);
                1: set_registers(16'd1, 16'd0, 16'd0, 16'd0, 16'd255);
                2: set_registers(16'd0, 16'hFFFF, 16'hFFFF, 16'd255, 16'd0);
                3: set_registers(16'hFFFF, 16'd300, 16'd100, 16'd2, 16'd9);
                default: set_registers(16'($urandom), 16'($urandom_range(0, 4000)),
                                       16'($urandom_range(0, 4000)), 16'($urandom),
                                       16'($urandom));
            endcase
            // long receiver hold-off while words keep coming
            if (ph == 2) hold_reqs <= hold_reqs + 1;
            if (ph == 5) begin
                run_random(ITEMS_PER_PHASE / 2);
                drain_pipeline;
                run_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            end else begin
                run_random(ITEMS_PER_PHASE);
            end
        end

        drain_pipeline;
        if (pending_actions.size() != 0)
            $error("%0d expected words never arrived", pending_actions.size());
        $display("covered %0d events: directed edge cases, %0d register settings, idle and stall mixes",
                 sent_count, PHASES);
        $display("checked %0d result words, %0d enter and %0d cancel among them",
                 n_results, n_enter, n_cancel);
        if (fail_cnt == 0 && pending_actions.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
